[rtl/cpp_pkg.sv]
// Shared constants, register indexes and types for the camera point projection block.
package cpp_pkg;

    localparam int C_W      = 50;           // camera-frame coordinate, signed Q.30
    localparam int M_W      = 49;           // magnitude of a camera-frame coordinate
    localparam int F_W      = 32;           // focal length width
    localparam int NUM_W    = F_W + M_W;    // f * |c|
    localparam int Q_W      = 32;           // quotient bits kept by the divider
    localparam int XF_LAT   = 5;
    localparam int DIV_LAT  = Q_W + 1;
    localparam int GAIN_LAT = 6;
    localparam int DIST_LAT = 6;
    localparam int G_W      = 63;           // |gain|, Q.32
    localparam int TERM_W   = 42;           // signed distorted term, Q16.16

    localparam logic [G_W-1:0] ONE_Q32 = 63'd1 << 32;

    localparam logic [2:0] CFG_ROT_A   = 3'd0;
    localparam logic [2:0] CFG_ROT_B   = 3'd1;
    localparam logic [2:0] CFG_ROT_C   = 3'd2;
    localparam logic [2:0] CFG_TRANS   = 3'd3;
    localparam logic [2:0] CFG_FOCAL   = 3'd4;
    localparam logic [2:0] CFG_KAPPA   = 3'd5;
    localparam logic [2:0] CFG_PSCALE  = 3'd6;
    localparam logic [2:0] CFG_ICENTER = 3'd7;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic depth_zero;
    } t_xf_ctl;

    typedef struct packed {
        logic depth_zero;
        logic clip;
    } t_side;

    typedef struct packed {
        logic [Q_W-1:0] mag;
        logic           neg;
    } t_lane;

endpackage

[rtl/cpp_xform.sv]
// World to camera frame transform and focal-length products, five stages.
module cpp_xform
    import cpp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [31:0]      i_world_x,
    input  logic signed [31:0]      i_world_y,
    input  logic signed [31:0]      i_world_z,
    input  logic [47:0]             i_rot_a,
    input  logic [47:0]             i_rot_b,
    input  logic [47:0]             i_rot_c,
    input  logic [62:0]             i_trans,
    input  logic [F_W-1:0]          i_focal,
    output logic                    o_valid,
    output t_xf_ctl                 o_ctl,
    output logic [NUM_W-1:0]        o_num_x,
    output logic [NUM_W-1:0]        o_num_y,
    output logic [M_W-1:0]          o_den
);

    logic [47:0]        rows [3];
    logic signed [31:0] w [3];

    logic [XF_LAT-1:0]  r_v;
    logic signed [47:0] r_prod [3][3];
    logic signed [C_W-1:0] r_c [3];
    logic [C_W-1:0]     n_abs [3];
    logic [M_W-1:0]     r_mag [3];
    logic               r_neg_x3, r_neg_y3, r_dz3;
    logic [56:0]        r_pl_x, r_pl_y;
    logic [55:0]        r_ph_x, r_ph_y;
    logic [M_W-1:0]     r_den4;
    t_xf_ctl            r_ctl4;
    logic [NUM_W-1:0]   r_num_x, r_num_y;
    logic [M_W-1:0]     r_den5;
    t_xf_ctl            r_ctl5;

    always_comb begin
        rows[0] = i_rot_a;
        rows[1] = i_rot_b;
        rows[2] = i_rot_c;
        w[0]    = i_world_x;
        w[1]    = i_world_y;
        w[2]    = i_world_z;
        for (int i = 0; i < 3; i++) begin
            n_abs[i] = r_c[i][C_W-1] ? (~r_c[i] + 50'd1) : r_c[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[XF_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // rotation products
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[i][j] <= $signed(rows[i][16*j +: 16]) * w[j];
            end
        end
        // translation scaled to Q.30 plus the row sums
        for (int i = 0; i < 3; i++) begin
            r_c[i] <= $signed({{7{i_trans[21*i+20]}}, i_trans[21*i +: 21], 22'b0})
                    + $signed({{2{r_prod[i][0][47]}}, r_prod[i][0]})
                    + $signed({{2{r_prod[i][1][47]}}, r_prod[i][1]})
                    + $signed({{2{r_prod[i][2][47]}}, r_prod[i][2]});
        end
        for (int i = 0; i < 3; i++) begin
            r_mag[i] <= n_abs[i][M_W-1:0];
        end
        r_neg_x3 <= r_c[0][C_W-1] ^ r_c[2][C_W-1];
        r_neg_y3 <= r_c[1][C_W-1] ^ r_c[2][C_W-1];
        r_dz3    <= (r_c[2] == '0);
        // f * |c| split into 25 + 24 bit halves
        r_pl_x   <= i_focal * r_mag[0][24:0];
        r_ph_x   <= i_focal * r_mag[0][48:25];
        r_pl_y   <= i_focal * r_mag[1][24:0];
        r_ph_y   <= i_focal * r_mag[1][48:25];
        r_den4   <= r_mag[2];
        r_ctl4   <= '{neg_x: r_neg_x3, neg_y: r_neg_y3, depth_zero: r_dz3};
        r_num_x  <= {24'b0, r_pl_x} + {r_ph_x, 25'b0};
        r_num_y  <= {24'b0, r_pl_y} + {r_ph_y, 25'b0};
        r_den5   <= r_den4;
        r_ctl5   <= r_ctl4;
    end

    assign o_valid = r_v[XF_LAT-1];
    assign o_ctl   = r_ctl5;
    assign o_num_x = r_num_x;
    assign o_num_y = r_num_y;
    assign o_den   = r_den5;

endmodule

[rtl/cpp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module cpp_div
    import cpp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [M_W-1:0]      i_den,
    output logic                o_valid,
    output logic [Q_W-1:0]      o_quo,
    output logic                o_ovf
);

    logic [DIV_LAT-1:0] r_v;
    logic [M_W-1:0]     r_rem [DIV_LAT];
    logic [Q_W-1:0]     r_low [DIV_LAT];
    logic [Q_W-1:0]     r_quo [DIV_LAT];
    logic [M_W-1:0]     r_den [DIV_LAT];
    logic               r_ovf [DIV_LAT];

    logic [M_W:0]       n_trial [DIV_LAT];
    logic [M_W:0]       n_diff  [DIV_LAT];
    logic               n_ge    [DIV_LAT];

    always_comb begin
        for (int s = 0; s < DIV_LAT; s++) begin
            n_trial[s] = {r_rem[s], r_low[s][Q_W-1]};
            n_diff[s]  = n_trial[s] - {1'b0, r_den[s]};
            n_ge[s]    = (n_trial[s] >= {1'b0, r_den[s]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[DIV_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // quotient of 2^32 or more saturates anyway
        r_rem[0] <= i_num[NUM_W-1:Q_W];
        r_low[0] <= i_num[Q_W-1:0];
        r_quo[0] <= '0;
        r_den[0] <= i_den;
        r_ovf[0] <= (i_num[NUM_W-1:Q_W] >= i_den);
        for (int s = 1; s < DIV_LAT; s++) begin
            r_rem[s] <= n_ge[s-1] ? n_diff[s-1][M_W-1:0] : n_trial[s-1][M_W-1:0];
            r_low[s] <= {r_low[s-1][Q_W-2:0], 1'b0};
            r_quo[s] <= {r_quo[s-1][Q_W-2:0], n_ge[s-1]};
            r_den[s] <= r_den[s-1];
            r_ovf[s] <= r_ovf[s-1];
        end
    end

    assign o_valid = r_v[DIV_LAT-1];
    assign o_quo   = r_quo[DIV_LAT-1];
    assign o_ovf   = r_ovf[DIV_LAT-1];

endmodule

[rtl/cpp_gain.sv]
// Radial distortion gain 1 + kappa*r^2 from the undistorted magnitudes, six stages.
module cpp_gain
    import cpp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [Q_W-1:0]      i_mag_x,
    input  logic [Q_W-1:0]      i_mag_y,
    input  logic signed [47:0]  i_kappa,
    output logic                o_valid,
    output logic [G_W-1:0]      o_gain_mag,
    output logic                o_gain_neg,
    output logic                o_clip
);

    logic [GAIN_LAT-1:0] r_v;
    logic [47:0]   kmag;
    logic          kneg;
    logic [G_W-1:0] ktop;
    logic [111:0]  n_p;
    logic [71:0]   n_sh;
    logic          n_kclip;

    logic [63:0]   r_sq_x, r_sq_y, r_r2;
    logic [63:0]   r_pp_ll, r_pp_lh;
    logic [47:0]   r_pp_hl, r_pp_hh;
    logic [95:0]   r_s1;
    logic [79:0]   r_s2;
    logic [G_W-1:0] r_km;
    logic          r_kclip5, r_kclip6;
    logic [G_W-1:0] r_gmag;
    logic          r_gneg;

    always_comb begin
        kneg    = i_kappa[47];
        kmag    = kneg ? (~i_kappa + 48'd1) : i_kappa;
        ktop    = (63'd1 << 62) | {62'b0, kneg};
        n_p     = {16'b0, r_s1} + {r_s2, 32'b0};
        n_sh    = n_p[111:40];
        n_kclip = (n_sh > {9'b0, ktop});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[GAIN_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_x   <= i_mag_x * i_mag_x;
        r_sq_y   <= i_mag_y * i_mag_y;
        r_r2     <= r_sq_x + r_sq_y;
        r_pp_ll  <= kmag[31:0]  * r_r2[31:0];
        r_pp_lh  <= kmag[31:0]  * r_r2[63:32];
        r_pp_hl  <= kmag[47:32] * r_r2[31:0];
        r_pp_hh  <= kmag[47:32] * r_r2[63:32];
        r_s1     <= {32'b0, r_pp_ll} + {r_pp_lh, 32'b0};
        r_s2     <= {32'b0, r_pp_hl} + {r_pp_hh, 32'b0};
        r_km     <= n_kclip ? ktop : n_sh[G_W-1:0];
        r_kclip5 <= n_kclip;
        // g = 1 + kr, kept as sign and magnitude
        if (!kneg) begin
            r_gmag <= ONE_Q32 + r_km;
            r_gneg <= 1'b0;
        end else if (r_km <= ONE_Q32) begin
            r_gmag <= ONE_Q32 - r_km;
            r_gneg <= 1'b0;
        end else begin
            r_gmag <= r_km - ONE_Q32;
            r_gneg <= 1'b1;
        end
        r_kclip6 <= r_kclip5;
    end

    assign o_valid    = r_v[GAIN_LAT-1];
    assign o_gain_mag = r_gmag;
    assign o_gain_neg = r_gneg;
    assign o_clip     = r_kclip6;

endmodule

[rtl/cpp_dist.sv]
// Distorted, pixel-scaled term u*g*scale/2^48 with saturation, six stages.
module cpp_dist
    import cpp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [Q_W-1:0]           i_mag,
    input  logic                     i_neg,
    input  logic [G_W-1:0]           i_gain_mag,
    input  logic                     i_gain_neg,
    input  logic [31:0]              i_scale,
    output logic                     o_valid,
    output logic signed [TERM_W-1:0] o_term,
    output logic                     o_clip
);

    logic [DIST_LAT-1:0] r_v;
    logic [DIST_LAT-2:0] r_neg;
    logic [63:0]  r_al;
    logic [62:0]  r_ah;
    logic [94:0]  r_a;
    logic [63:0]  r_p0, r_p1;
    logic [62:0]  r_p2, r_p2b;
    logic [95:0]  r_s1;
    logic [126:0] n_p;
    logic [78:0]  n_t;
    logic [40:0]  top;
    logic         n_clip;
    logic [40:0]  r_tmag;
    logic         r_clip5, r_clip6;
    logic signed [TERM_W-1:0] r_term;

    always_comb begin
        n_p    = {31'b0, r_s1} + {r_p2b, 64'b0};
        n_t    = n_p[126:48];
        top    = (41'd1 << 40) | {40'b0, r_neg[3]};
        n_clip = (n_t > {38'b0, top});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[DIST_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg   <= {r_neg[DIST_LAT-3:0], i_neg ^ i_gain_neg};
        r_al    <= i_mag * i_gain_mag[31:0];
        r_ah    <= i_mag * i_gain_mag[62:32];
        r_a     <= {31'b0, r_al} + {r_ah, 32'b0};
        r_p0    <= r_a[31:0]  * i_scale;
        r_p1    <= r_a[63:32] * i_scale;
        r_p2    <= r_a[94:64] * i_scale;
        r_s1    <= {32'b0, r_p0} + {r_p1, 32'b0};
        r_p2b   <= r_p2;
        r_tmag  <= n_clip ? top : n_t[40:0];
        r_clip5 <= n_clip;
        r_term  <= r_neg[4] ? -$signed({1'b0, r_tmag}) : $signed({1'b0, r_tmag});
        r_clip6 <= r_clip5;
    end

    assign o_valid = r_v[DIST_LAT-1];
    assign o_term  = r_term;
    assign o_clip  = r_clip6;

endmodule

[rtl/camera_point_projection.sv]
// Top level: pinhole projection of world points with one radial distortion term.
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------------------
//  point in  | start, busy (always 0) | i_world_x, i_world_y, i_world_z
//  result    | o_valid, one cycle     | o_pixel_x, o_pixel_y, o_depth_zero, o_clipped
//  config    | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// One item is taken every cycle, and results come out in the order their items went in.
// The depth is set by the 33-stage divider (one quotient bit per stage) plus the
// transform (5), saturation (1), gain (6), distortion (6) and output (2) stages.
// Reset clears the valid bits and loads the default calibration.
// Nothing stalls: the receiver takes every result in the cycle it is shown.
module camera_point_projection
    import cpp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_world_x,
    input  logic signed [31:0] i_world_y,
    input  logic signed [31:0] i_world_z,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_pixel_x,
    output logic signed [31:0] o_pixel_y,
    output logic               o_depth_zero,
    output logic               o_clipped
);

    // calibration registers
    logic [47:0] r_rot_a, r_rot_b, r_rot_c;
    logic [62:0] r_trans;
    logic [31:0] r_focal;
    logic signed [47:0] r_kappa;
    logic [63:0] r_pscale;
    logic [47:0] r_icenter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_a   <= 48'd16384;
            r_rot_b   <= 48'd16384 << 16;
            r_rot_c   <= 48'd16384 << 32;
            r_trans   <= '0;
            r_focal   <= 32'd65536;
            r_kappa   <= '0;
            r_pscale  <= {32'd65536, 32'd65536};
            r_icenter <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROT_A:   r_rot_a   <= i_cfg_data[47:0];
                CFG_ROT_B:   r_rot_b   <= i_cfg_data[47:0];
                CFG_ROT_C:   r_rot_c   <= i_cfg_data[47:0];
                CFG_TRANS:   r_trans   <= i_cfg_data[62:0];
                CFG_FOCAL:   r_focal   <= i_cfg_data[31:0];
                CFG_KAPPA:   r_kappa   <= i_cfg_data[47:0];
                CFG_PSCALE:  r_pscale  <= i_cfg_data;
                CFG_ICENTER: r_icenter <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // camera frame and f*|c|
    logic             xf_valid;
    t_xf_ctl          xf_ctl;
    logic [NUM_W-1:0] xf_num_x, xf_num_y;
    logic [M_W-1:0]   xf_den;

    cpp_xform u_xform (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start & ~busy),
        .i_world_x (i_world_x),
        .i_world_y (i_world_y),
        .i_world_z (i_world_z),
        .i_rot_a   (r_rot_a),
        .i_rot_b   (r_rot_b),
        .i_rot_c   (r_rot_c),
        .i_trans   (r_trans),
        .i_focal   (r_focal),
        .o_valid   (xf_valid),
        .o_ctl     (xf_ctl),
        .o_num_x   (xf_num_x),
        .o_num_y   (xf_num_y),
        .o_den     (xf_den)
    );

    // one divider lane per image axis, sharing the depth
    logic           dx_valid, dy_valid;
    logic [Q_W-1:0] dx_quo, dy_quo;
    logic           dx_ovf, dy_ovf;

    cpp_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (xf_valid),
        .i_num   (xf_num_x),
        .i_den   (xf_den),
        .o_valid (dx_valid),
        .o_quo   (dx_quo),
        .o_ovf   (dx_ovf)
    );

    cpp_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (xf_valid),
        .i_num   (xf_num_y),
        .i_den   (xf_den),
        .o_valid (dy_valid),
        .o_quo   (dy_quo),
        .o_ovf   (dy_ovf)
    );

    // signs and zero-depth flag ride alongside the divider
    t_xf_ctl r_dly_ctl [DIV_LAT];

    always_ff @(posedge i_clk) begin
        r_dly_ctl[0] <= xf_ctl;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_dly_ctl[k] <= r_dly_ctl[k-1];
        end
    end

    // saturate the undistorted position, sign-magnitude form kept
    t_xf_ctl        dctl;
    logic [Q_W-1:0] top_x, top_y;
    logic           n_cl_x, n_cl_y;
    logic           r_s_v;
    t_lane          r_s_x, r_s_y;
    t_side          r_s_side;

    always_comb begin
        dctl   = r_dly_ctl[DIV_LAT-1];
        top_x  = dctl.neg_x ? 32'h8000_0000 : 32'h7FFF_FFFF;
        top_y  = dctl.neg_y ? 32'h8000_0000 : 32'h7FFF_FFFF;
        n_cl_x = dx_ovf | (dx_quo > top_x);
        n_cl_y = dy_ovf | (dy_quo > top_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else begin
            r_s_v <= dx_valid & dy_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_x    <= '{mag: n_cl_x ? top_x : dx_quo, neg: dctl.neg_x};
        r_s_y    <= '{mag: n_cl_y ? top_y : dy_quo, neg: dctl.neg_y};
        r_s_side <= '{depth_zero: dctl.depth_zero, clip: n_cl_x | n_cl_y};
    end

    // distortion gain
    logic           g_valid;
    logic [G_W-1:0] g_mag;
    logic           g_neg, g_clip;

    cpp_gain u_gain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s_v),
        .i_mag_x    (r_s_x.mag),
        .i_mag_y    (r_s_y.mag),
        .i_kappa    (r_kappa),
        .o_valid    (g_valid),
        .o_gain_mag (g_mag),
        .o_gain_neg (g_neg),
        .o_clip     (g_clip)
    );

    t_lane r_g_x [GAIN_LAT];
    t_lane r_g_y [GAIN_LAT];
    t_side r_g_side [GAIN_LAT];

    always_ff @(posedge i_clk) begin
        r_g_x[0]    <= r_s_x;
        r_g_y[0]    <= r_s_y;
        r_g_side[0] <= r_s_side;
        for (int k = 1; k < GAIN_LAT; k++) begin
            r_g_x[k]    <= r_g_x[k-1];
            r_g_y[k]    <= r_g_y[k-1];
            r_g_side[k] <= r_g_side[k-1];
        end
    end

    // distorted terms per axis
    logic                     tx_valid, ty_valid;
    logic signed [TERM_W-1:0] tx_term, ty_term;
    logic                     tx_clip, ty_clip;

    cpp_dist u_dist_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (g_valid),
        .i_mag      (r_g_x[GAIN_LAT-1].mag),
        .i_neg      (r_g_x[GAIN_LAT-1].neg),
        .i_gain_mag (g_mag),
        .i_gain_neg (g_neg),
        .i_scale    (r_pscale[31:0]),
        .o_valid    (tx_valid),
        .o_term     (tx_term),
        .o_clip     (tx_clip)
    );

    cpp_dist u_dist_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (g_valid),
        .i_mag      (r_g_y[GAIN_LAT-1].mag),
        .i_neg      (r_g_y[GAIN_LAT-1].neg),
        .i_gain_mag (g_mag),
        .i_gain_neg (g_neg),
        .i_scale    (r_pscale[63:32]),
        .o_valid    (ty_valid),
        .o_term     (ty_term),
        .o_clip     (ty_clip)
    );

    t_side r_t_side [DIST_LAT];

    always_ff @(posedge i_clk) begin
        r_t_side[0] <= '{depth_zero: r_g_side[GAIN_LAT-1].depth_zero,
                         clip: r_g_side[GAIN_LAT-1].clip | g_clip};
        for (int k = 1; k < DIST_LAT; k++) begin
            r_t_side[k] <= r_t_side[k-1];
        end
    end

    // principal point offsets, Q12.4 moved to Q16.16
    logic signed [16:0] cdiff;
    logic signed [42:0] off_x, off_y;

    always_comb begin
        cdiff = $signed({1'b0, r_icenter[47:32]}) - $signed({1'b0, r_icenter[15:0]});
        off_x = $signed({{14{cdiff[16]}}, cdiff, 12'b0});
        off_y = $signed({15'b0, r_icenter[31:16], 12'b0});
    end

    logic               r_f_v;
    logic signed [42:0] r_f_sx, r_f_sy;
    t_side              r_f_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else begin
            r_f_v <= tx_valid & ty_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_sx   <= off_x + $signed({tx_term[TERM_W-1], tx_term});
        r_f_sy   <= off_y + $signed({ty_term[TERM_W-1], ty_term});
        r_f_side <= '{depth_zero: r_t_side[DIST_LAT-1].depth_zero,
                      clip: r_t_side[DIST_LAT-1].clip | tx_clip | ty_clip};
    end

    // final clamp to 32 bits; zero depth overrides everything
    logic        n_sat_x, n_sat_y;
    logic [31:0] n_px, n_py;

    always_comb begin
        n_sat_x = ~((&r_f_sx[42:31]) | ~(|r_f_sx[42:31]));
        n_sat_y = ~((&r_f_sy[42:31]) | ~(|r_f_sy[42:31]));
        n_px    = n_sat_x ? (r_f_sx[42] ? 32'h8000_0000 : 32'h7FFF_FFFF) : r_f_sx[31:0];
        n_py    = n_sat_y ? (r_f_sy[42] ? 32'h8000_0000 : 32'h7FFF_FFFF) : r_f_sy[31:0];
    end

    logic        r_o_v;
    logic [31:0] r_o_px, r_o_py;
    logic        r_o_dz, r_o_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_f_side.depth_zero) begin
            r_o_px   <= '0;
            r_o_py   <= '0;
            r_o_dz   <= 1'b1;
            r_o_clip <= 1'b0;
        end else begin
            r_o_px   <= n_px;
            r_o_py   <= n_py;
            r_o_dz   <= 1'b0;
            r_o_clip <= r_f_side.clip | n_sat_x | n_sat_y;
        end
    end

    assign o_valid      = r_o_v;
    assign o_pixel_x    = $signed(r_o_px);
    assign o_pixel_y    = $signed(r_o_py);
    assign o_depth_zero = r_o_dz;
    assign o_clipped    = r_o_clip;

endmodule

[tb/cpp_checker.sv]
// Scoreboard for the camera point projection block: predicts each pixel and compares.
module cpp_checker
    import cpp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic signed [31:0] i_world_x,
    input  logic signed [31:0] i_world_y,
    input  logic signed [31:0] i_world_z,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic signed [31:0] i_pixel_x,
    input  logic signed [31:0] i_pixel_y,
    input  logic               i_depth_zero,
    input  logic               i_clipped,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results
);

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               dz;
        logic               clip;
    } t_pixel;

    t_pixel expected_pixels[$];

    // local copy of the calibration
    logic [47:0]        rot_a, rot_b, rot_c;
    logic [62:0]        trans;
    logic [31:0]        focal;
    logic signed [47:0] kappa;
    logic [63:0]        pscale;
    logic [47:0]        icenter;

    int fail_count, pending, results;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_results    = results;

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // magnitude to signed value, clamped to [-(lim+1), lim]
    function automatic logic signed [63:0] clamp_mag(input logic [127:0] m, input logic neg,
                                                     input logic [63:0] lim, inout logic clip);
        logic [63:0] top;
        top = neg ? lim + 64'd1 : lim;
        if (m > {64'd0, top}) begin
            m    = {64'd0, top};
            clip = 1'b1;
        end
        return neg ? -$signed(m[63:0]) : $signed(m[63:0]);
    endfunction

    // f*cn/cz, truncated toward zero
    function automatic logic signed [63:0] project_axis(input logic signed [63:0] cn,
                                                        input logic signed [63:0] cz,
                                                        inout logic clip);
        logic [127:0] num;
        logic [127:0] quo;
        num = {96'd0, focal} * {64'd0, magnitude(cn)};
        quo = num / {64'd0, magnitude(cz)};
        return clamp_mag(quo, (cn < 0) != (cz < 0), 64'h7FFF_FFFF, clip);
    endfunction

    function automatic logic signed [63:0] distort_axis(input logic signed [63:0] u,
                                                        input logic signed [63:0] g,
                                                        input logic [31:0] scale,
                                                        inout logic clip);
        logic [127:0] p;
        p = {64'd0, magnitude(u)} * {64'd0, magnitude(g)};
        p = p * {96'd0, scale};
        return clamp_mag(p >> 48, (u < 0) != (g < 0), 64'd1 << 40, clip);
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v, inout logic clip);
        if (v > 64'sd2147483647) begin
            clip = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clip = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic t_pixel predict_pixel(input logic signed [31:0] wx,
                                             input logic signed [31:0] wy,
                                             input logic signed [31:0] wz);
        logic [47:0]        rows [3];
        logic signed [63:0] w [3];
        logic signed [63:0] c [3];
        logic signed [63:0] acc, xu, yu, kr, g, k64, cx0, cy0, ncx, px, py;
        logic [63:0]        r2;
        logic               clip;
        t_pixel             r;
        rows[0] = rot_a;
        rows[1] = rot_b;
        rows[2] = rot_c;
        w[0] = wx;
        w[1] = wy;
        w[2] = wz;
        // camera frame in Q.30: R*w + t*2^22
        for (int i = 0; i < 3; i++) begin
            acc = $signed(trans[21*i +: 21]) * 64'sd4194304;
            for (int j = 0; j < 3; j++)
                acc += $signed(rows[i][16*j +: 16]) * w[j];
            c[i] = acc;
        end
        if (c[2] == 0) begin
            r = '{px: 0, py: 0, dz: 1'b1, clip: 1'b0};
            return r;
        end
        clip = 1'b0;
        xu   = project_axis(c[0], c[2], clip);
        yu   = project_axis(c[1], c[2], clip);
        r2   = magnitude(xu) * magnitude(xu) + magnitude(yu) * magnitude(yu);
        k64  = kappa;
        kr   = clamp_mag(({64'd0, magnitude(k64)} * {64'd0, r2}) >> 40, k64 < 0,
                         64'd1 << 62, clip);
        g    = (64'sd1 <<< 32) + kr;
        cx0  = {48'd0, icenter[15:0]};
        cy0  = {48'd0, icenter[31:16]};
        ncx  = {48'd0, icenter[47:32]};
        px   = (ncx - cx0) * 64'sd4096 + distort_axis(xu, g, pscale[31:0], clip);
        py   = cy0 * 64'sd4096 + distort_axis(yu, g, pscale[63:32], clip);
        px   = clamp32(px, clip);
        py   = clamp32(py, clip);
        r    = '{px: px[31:0], py: py[31:0], dz: 1'b0, clip: clip};
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pixel exp_pix;
        if (!i_rst_n) begin
            rot_a      <= 48'd16384;
            rot_b      <= 48'd16384 << 16;
            rot_c      <= 48'd16384 << 32;
            trans      <= '0;
            focal      <= 32'd65536;
            kappa      <= '0;
            pscale     <= {32'd65536, 32'd65536};
            icenter    <= '0;
            expected_pixels.delete();
            fail_count = 0;
            pending    = 0;
            results    = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROT_A:   rot_a   <= i_cfg_data[47:0];
                    CFG_ROT_B:   rot_b   <= i_cfg_data[47:0];
                    CFG_ROT_C:   rot_c   <= i_cfg_data[47:0];
                    CFG_TRANS:   trans   <= i_cfg_data[62:0];
                    CFG_FOCAL:   focal   <= i_cfg_data[31:0];
                    CFG_KAPPA:   kappa   <= i_cfg_data[47:0];
                    CFG_PSCALE:  pscale  <= i_cfg_data;
                    CFG_ICENTER: icenter <= i_cfg_data[47:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                expected_pixels.insert(expected_pixels.size(),
                                       predict_pixel(i_world_x, i_world_y, i_world_z));
                pending++;
            end
            if (i_valid) begin
                results++;
                if (expected_pixels.size() == 0) begin
                    $error("result with no item outstanding: px %0d py %0d",
                           i_pixel_x, i_pixel_y);
                    fail_count++;
                end else begin
                    exp_pix = expected_pixels.pop_front();
                    pending--;
                    if (i_pixel_x !== exp_pix.px) begin
                        $error("pixel_x expected %0d got %0d", exp_pix.px, i_pixel_x);
                        fail_count++;
                    end
                    if (i_pixel_y !== exp_pix.py) begin
                        $error("pixel_y expected %0d got %0d", exp_pix.py, i_pixel_y);
                        fail_count++;
                    end
                    if (i_depth_zero !== exp_pix.dz) begin
                        $error("depth_zero expected %0b got %0b", exp_pix.dz, i_depth_zero);
                        fail_count++;
                    end
                    if (i_clipped !== exp_pix.clip) begin
                        $error("clipped expected %0b got %0b", exp_pix.clip, i_clipped);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

[tb/tb_camera_point_projection.sv]
// Testbench top for the camera point projection block: stimulus, calibration and verdict.
module tb_camera_point_projection
    import cpp_pkg::*;
();

    localparam int PIPE_LAT       = 53;     // item to result
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with nothing accepted
    localparam int ITEMS_PER_CAL  = 150;

    // calibration styles
    typedef enum int {CAL_RESET, CAL_PLAIN, CAL_WILD, CAL_EXTREME_HI, CAL_EXTREME_LO} t_cal;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_world_x, i_world_y, i_world_z;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [63:0]        i_cfg_data;
    logic               o_valid;
    logic signed [31:0] o_pixel_x, o_pixel_y;
    logic               o_depth_zero, o_clipped;

    int fail_count, pending, results;
    int idle_cycles;
    int idle_pct;
    int points_sent;

    camera_point_projection i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_world_x    (i_world_x),
        .i_world_y    (i_world_y),
        .i_world_z    (i_world_z),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_depth_zero (o_depth_zero),
        .o_clipped    (o_clipped)
    );

    cpp_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_world_x    (i_world_x),
        .i_world_y    (i_world_y),
        .i_world_z    (i_world_z),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (o_valid),
        .i_pixel_x    (o_pixel_x),
        .i_pixel_y    (o_pixel_y),
        .i_depth_zero (o_depth_zero),
        .i_clipped    (o_clipped),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // watchdog: any cycle that accepts an item or a result restarts the count
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("camera_point_projection: mismatch");
            $finish;
        end
    end

    // Present one item and hold it until it is taken. busy is looked at on the
    // falling edge, where it is settled for the coming rising edge.
    task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        start     <= 1'b1;
        i_world_x <= x;
        i_world_y <= y;
        i_world_z <= z;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        points_sent++;
        // each following cycle idles with probability idle_pct; start only drops for a gap
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
    endtask

    // Stop sending and let every outstanding item come back, then the pipe settle.
    task automatic drain;
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_rot(input int spread);
        return 16'($urandom_range(0, 2 * spread) - spread);
    endfunction

    // Writes all eight registers back to back; only called with the block drained.
    task automatic load_calibration(input t_cal style);
        logic [63:0] regs [8];
        logic [20:0] tz;
        case (style)
            CAL_RESET: begin
                regs[CFG_ROT_A]   = 64'd16384;
                regs[CFG_ROT_B]   = 64'd16384 << 16;
                regs[CFG_ROT_C]   = 64'd16384 << 32;
                regs[CFG_TRANS]   = 64'd0;
                regs[CFG_FOCAL]   = 64'd65536;
                regs[CFG_KAPPA]   = 64'd0;
                regs[CFG_PSCALE]  = {32'd65536, 32'd65536};
                regs[CFG_ICENTER] = 64'd0;
            end
            CAL_PLAIN: begin
                // near-identity rotation, a real lens and a sensible sensor
                regs[CFG_ROT_A]   = {16'd0, rand_rot(2000), rand_rot(2000),
                                     16'(16384 - $urandom_range(0, 800))};
                regs[CFG_ROT_B]   = {16'd0, rand_rot(2000),
                                     16'(16384 - $urandom_range(0, 800)), rand_rot(2000)};
                regs[CFG_ROT_C]   = {16'd0, 16'(16384 - $urandom_range(0, 800)),
                                     rand_rot(2000), rand_rot(2000)};
                tz = ($urandom_range(3) == 0) ? 21'd0 : 21'($urandom_range(0, 1000 << 8));
                regs[CFG_TRANS]   = {1'($urandom), tz,
                                     21'($urandom_range(0, 200 << 8) - (100 << 8)),
                                     21'($urandom_range(0, 200 << 8) - (100 << 8))};
                regs[CFG_FOCAL]   = 64'($urandom_range(4, 16)) << 16;
                regs[CFG_KAPPA]   = 64'(signed'($urandom_range(0, 1 << 28)) - (1 << 27));
                regs[CFG_PSCALE]  = {32'($urandom_range(50, 200) << 16),
                                     32'($urandom_range(50, 200) << 16)};
                regs[CFG_ICENTER] = {16'($urandom_range(0, 640 << 4)),
                                     16'($urandom_range(0, 480 << 4)),
                                     16'($urandom_range(0, 640 << 4))};
            end
            CAL_WILD: begin
                // every bit at random, upper bits beyond each register's width included
                foreach (regs[i]) regs[i] = {$urandom, $urandom};
            end
            CAL_EXTREME_HI: begin
                regs[CFG_ROT_A]   = {16'($urandom), 16'h7FFF, 16'h8000, 16'h7FFF};
                regs[CFG_ROT_B]   = {16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000};
                regs[CFG_ROT_C]   = {16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF};
                regs[CFG_TRANS]   = {1'b1, 21'h0FFFFF, 21'h100000, 21'h0FFFFF};
                regs[CFG_FOCAL]   = 64'hFFFF_FFFF;
                regs[CFG_KAPPA]   = 64'hFFFF_8000_0000_0000;  // most negative kappa
                regs[CFG_PSCALE]  = '1;
                regs[CFG_ICENTER] = 64'h0000_FFFF_FFFF_FFFF;
            end
            default: begin
                // smallest focal length, largest kappa, zero pixel scale
                regs[CFG_ROT_A]   = 64'd0;
                regs[CFG_ROT_B]   = {16'd0, 16'd0, 16'd1, 16'hFFFF};
                regs[CFG_ROT_C]   = {16'd0, 16'h0001, 16'd0, 16'd0};
                regs[CFG_TRANS]   = {1'b0, 21'd1, 21'h100000, 21'd0};
                regs[CFG_FOCAL]   = 64'd1;
                regs[CFG_KAPPA]   = 64'h0000_7FFF_FFFF_FFFF;
                regs[CFG_PSCALE]  = 64'd0;
                regs[CFG_ICENTER] = 64'h0000_0000_FFFF_0000;
            end
        endcase
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(i);
            i_cfg_data <= regs[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly points ahead at working distances, some near the origin, the rest noise.
    task automatic send_random_point;
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            send_point(32'($urandom_range(0, 1000 << 16) - (500 << 16)),
                       32'($urandom_range(0, 1000 << 16) - (500 << 16)),
                       32'($urandom_range(100 << 16, 5000 << 16)));
        else if (pick < 73)
            send_point(32'd0, 32'd0, 32'd0);
        else if (pick < 78)
            send_point(32'($urandom_range(0, 200) - 100), 32'($urandom_range(0, 200) - 100),
                       32'($urandom_range(0, 8)));
        else
            send_point($urandom, $urandom, $urandom);
    endtask

    initial begin
        t_cal cal;
        start       = 1'b0;
        i_world_x   = '0;
        i_world_y   = '0;
        i_world_z   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        idle_cycles = 0;
        idle_pct    = 20;
        points_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, on the reset calibration: zero depth (origin and off-axis),
        // field extremes, the sign quadrants and a far-off point that saturates.
        send_point(32'd0, 32'd0, 32'd0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
        send_point(32'hFFFF_0000, 32'hFFFE_0000, 32'h0001_0000);
        send_point(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // zero focal length lies outside the range but must still give xu = yu = 0
        load_calibration(CAL_PLAIN);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FOCAL;
        i_cfg_data <= 64'd0;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        send_point(32'h0064_0000, 32'hFF9C_0000, 32'h03E8_0000);
        send_point(32'd0, 32'd0, 32'd0);
        drain();

        load_calibration(CAL_EXTREME_HI);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF);
        send_point(32'h1234_5678, 32'h8765_4321, 32'h0000_0010);
        drain();

        load_calibration(CAL_EXTREME_LO);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'd0, 32'd0, 32'd0);
        send_point(32'h0000_1000, 32'hFFFF_F000, 32'h0000_0001);
        drain();

        // Random part: three idling profiles, each through three calibrations,
        // with a full drain in the middle of every block.
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 20 : (phase == 1) ? 75 : 0;
            for (int blk = 0; blk < 3; blk++) begin
                case ((phase * 3 + blk) % 5)
                    0, 2:    cal = CAL_PLAIN;
                    1:       cal = CAL_WILD;
                    3:       cal = CAL_EXTREME_HI;
                    default: cal = CAL_EXTREME_LO;
                endcase
                load_calibration(cal);
                for (int n = 0; n < ITEMS_PER_CAL; n++) begin
                    send_random_point();
                    if (n == ITEMS_PER_CAL / 2)
                        drain();
                end
                drain();
            end
        end

        $display("covered %0d points over reset, plain, random and extreme calibrations,",
                 points_sent);
        $display("with gaps of 20%%, 75%% and none; %0d results checked", results);
        if (fail_count == 0 && pending == 0)
            $display("camera_point_projection: match");
        else
            $display("camera_point_projection: mismatch");
        $finish;
    end

endmodule
